// ----- hw/rtl/tinted_premul_over_blend_macros.svh -----
// Assertion macros shared by the compositor RTL.
// Used by tinted_premul_over_blend.sv; expects clk and rst_n in scope.
`ifndef TINTED_PREMUL_OVER_BLEND_MACROS_SVH
`define TINTED_PREMUL_OVER_BLEND_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define TPOB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tpob assertion failed");
// Condition now implies a result in the next cycle.
`define TPOB_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("tpob assertion failed");
`else
`define TPOB_ASSERT(lbl, prop)
`define TPOB_ASSERT_NEXT(lbl, cond, res)
`endif

`endif

// ----- hw/rtl/tpob_pkg.sv -----
// Package for the tinted premultiplied source-over compositor.
// Holds channel widths and the exact divide-by-255 helper; no dependencies.
`default_nettype none

package tpob_pkg;

  localparam int ChanW    = 8;
  localparam int ProdW    = 2 * ChanW;
  localparam int TintW    = 3 * ChanW;
  localparam int PixelW   = 4 * ChanW;
  localparam int InDataW  = 48;
  localparam int OutDataW = 32;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // Floor of v / 255, exact for every v up to 255 * 255.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] v);
    logic [ProdW:0] x;
    x = {1'b0, v} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW + 1){1'b0}}, v[ProdW-1:ChanW]};
    return x[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tinted_premul_over_blend.sv -----
// Tinted premultiplied source-over compositor, five-stage pipeline.
// Depends on tpob_pkg and tinted_premul_over_blend_macros.svh.
//
// Usage:
//   in_*  : one item per pixel: source alpha, luminance and destination ARGB.
//   out_* : one result per item, in order: composited ARGB in out_tdata and
//           the written flag in out_tuser (0 when the source alpha is zero).
//   cfg_* : tint color, written with cfg_we while no item is in flight.
// Throughput is one item per clock cycle while the receiver keeps out_tready
// high. Each item passes through the five registered stages in order: tint mix
// multiply, divide by 255, alpha and inverse-alpha multiplies, divide by 255,
// then the final add.
// Every stage has its own valid bit and advances when the stage after it
// is empty or moving, so bubbles close up while the receiver stalls; with
// the pipe full and out_tready low, in_tready drops and nothing is lost.
// Synchronous active-low reset empties the pipeline and clears the tint.
`default_nettype none
`include "tinted_premul_over_blend_macros.svh"

module tinted_premul_over_blend (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,     // tint_color: blue 7:0, green 15:8, red 23:16
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,      // src_alpha 7:0, src_lum 15:8, dst_pixel 47:16
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // out_pixel 31:0
  output logic             out_tuser      // written 0
);

  localparam int CW = tpob_pkg::ChanW;
  localparam int PW = tpob_pkg::ProdW;
  localparam logic [CW-1:0] AOpaque = tpob_pkg::ChanMax;

  logic [tpob_pkg::TintW-1:0] tint_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s4_move;

  logic [CW-1:0]                a1_r, a2_r, a3_r, a4_r;
  logic [tpob_pkg::PixelW-1:0]  dst1_r, dst2_r, dst3_r, dst4_r;
  logic [2:0][PW-1:0]           mixn1_r, mixn1_nxt;
  logic [2:0][CW-1:0]           mix2_r, mix2_nxt;
  logic [2:0][PW-1:0]           pm3_r, pm3_nxt;
  logic [3:0][PW-1:0]           dp3_r, dp3_nxt;
  logic [2:0][CW-1:0]           src4_r, src4_nxt;
  logic [3:0][CW-1:0]           dq4_r, dq4_nxt;
  logic [31:0]                  pix5_r, pix5_nxt;
  logic                         wr5_r, wr5_nxt;

  logic [CW-1:0]               in_alpha, in_lum;
  logic [tpob_pkg::PixelW-1:0] in_dst;

  assign in_alpha = in_tdata[7:0];
  assign in_lum   = in_tdata[15:8];
  assign in_dst   = in_tdata[47:16];

  // Each stage may load when it is empty or its contents move on.
  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign s4_move = rdy5 && v4_r;

  // Stage 1: c*(255-lum) + 255*lum per color channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mixn1_nxt[ch] = {{CW{1'b0}}, tint_r[CW*ch +: CW]} * {{CW{1'b0}}, ~in_lum}
                    + {in_lum, {CW{1'b0}}} - {{CW{1'b0}}, in_lum};
    end
  end

  // Stage 2: mixed color, divided by 255.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mix2_nxt[ch] = tpob_pkg::div255(mixn1_r[ch]);
    end
  end

  // Stage 3: premultiply by alpha and scale destination by inverse alpha.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pm3_nxt[ch] = {{CW{1'b0}}, mix2_r[ch]} * {{CW{1'b0}}, a2_r};
    end
    for (int ch = 0; ch < 4; ch++) begin
      dp3_nxt[ch] = {{CW{1'b0}}, dst2_r[CW*ch +: CW]} * {{CW{1'b0}}, ~a2_r};
    end
  end

  // Stage 4: both products divided by 255.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      src4_nxt[ch] = tpob_pkg::div255(pm3_r[ch]);
    end
    for (int ch = 0; ch < 4; ch++) begin
      dq4_nxt[ch] = tpob_pkg::div255(dp3_r[ch]);
    end
  end

  // Stage 5: source over destination; a transparent source leaves it alone.
  always_comb begin
    if (a4_r == '0) begin
      pix5_nxt = dst4_r;
      wr5_nxt  = 1'b0;
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        pix5_nxt[CW*ch +: CW] = src4_r[ch] + dq4_r[ch];
      end
      pix5_nxt[CW*3 +: CW] = a4_r + dq4_r[3];
      wr5_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        tint_r <= cfg_wdata;
      end
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a1_r    <= in_alpha;
      dst1_r  <= in_dst;
      mixn1_r <= mixn1_nxt;
    end
    if (rdy2) begin
      a2_r   <= a1_r;
      dst2_r <= dst1_r;
      mix2_r <= mix2_nxt;
    end
    if (rdy3) begin
      a3_r   <= a2_r;
      dst3_r <= dst2_r;
      pm3_r  <= pm3_nxt;
      dp3_r  <= dp3_nxt;
    end
    if (rdy4) begin
      a4_r   <= a3_r;
      dst4_r <= dst3_r;
      src4_r <= src4_nxt;
      dq4_r  <= dq4_nxt;
    end
    if (rdy5) begin
      pix5_r <= pix5_nxt;
      wr5_r  <= wr5_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = pix5_r;
  assign out_tuser  = wr5_r;

  `TPOB_ASSERT_NEXT(a_pass_dst, s4_move && a4_r == '0, !out_tuser && out_tdata == $past(dst4_r))
  `TPOB_ASSERT_NEXT(a_opaque_alpha, s4_move && a4_r == AOpaque, out_tuser && &out_tdata[31:24])
  `TPOB_ASSERT_NEXT(a_stage3_hold, v3_r && !rdy4, v3_r && $stable(a3_r) && $stable(dst3_r))
  `TPOB_ASSERT(a_ready_chain, !in_tready |-> v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready)

endmodule

`default_nettype wire

// ----- bench/over_blend_checker.sv -----
`timescale 1ns / 100ps
// Checker for the tinted premultiplied source-over compositor.
// It watches the tint writes and both streams, predicts each pixel and compares.
// It depends on tpob_pkg for the channel widths.

module over_blend_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpob_pkg::TintW-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [tpob_pkg::InDataW-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [tpob_pkg::OutDataW-1:0] out_tdata,
  input  logic                          out_tuser,
  output int                            errors,
  output int                            pending
);

  localparam int          ChanW  = tpob_pkg::ChanW;
  localparam int          TintW  = tpob_pkg::TintW;
  localparam int          PixelW = tpob_pkg::PixelW;
  localparam int unsigned ChanTop = 255;
  localparam int          ShownMax = 100;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              written;
  } blended_t;

  logic [TintW-1:0] tint_now;
  blended_t         pixel_due[$];
  int               mismatch_count = 0;
  int               due_count = 0;

  assign errors  = mismatch_count;
  assign pending = due_count;

  function automatic blended_t composite_pixel(input logic [TintW-1:0] tint,
                                               input logic [ChanW-1:0] alpha,
                                               input logic [ChanW-1:0] lum,
                                               input logic [PixelW-1:0] dst);
    blended_t    res;
    int unsigned a, l, inv, c, mixed, src, d;
    a   = alpha;
    l   = lum;
    inv = ChanTop - a;
    res.written = (alpha != '0);
    res.pixel   = dst;
    if (alpha != '0) begin
      // Channel 3 is alpha itself; the three below are the mixed, premultiplied tint.
      for (int k = 0; k < 4; k++) begin
        if (k == 3) begin
          src = a;
        end else begin
          c     = tint[k*ChanW +: ChanW];
          mixed = (c * (ChanTop - l) + ChanTop * l) / ChanTop;
          src   = (mixed * a) / ChanTop;
        end
        d = dst[k*ChanW +: ChanW];
        res.pixel[k*ChanW +: ChanW] = ChanW'(src + (d * inv) / ChanTop);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [PixelW-1:0] got,
                                 input logic [PixelW-1:0] want);
    if (mismatch_count < ShownMax)
      $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    blended_t want;
    if (!rst_n) begin
      tint_now = '0;
      pixel_due.delete();
    end else begin
      if (cfg_we)
        tint_now = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (pixel_due.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = pixel_due.pop_front();
          if (out_tdata !== want.pixel)
            report_mismatch("out_pixel", out_tdata, want.pixel);
          if (out_tuser !== want.written)
            report_mismatch("written", PixelW'(out_tuser), PixelW'(want.written));
        end
      end
      if (in_tvalid && in_tready)
        pixel_due.push_back(composite_pixel(tint_now, in_tdata[7:0], in_tdata[15:8],
                                            in_tdata[47:16]));
    end
    due_count = pixel_due.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for tinted_premul_over_blend: clock, reset, stimulus and verdict.
// It depends on tpob_pkg, the block itself and over_blend_checker.

module tb;

  localparam int TintW    = tpob_pkg::TintW;
  localparam int InDataW  = tpob_pkg::InDataW;
  localparam int OutDataW = tpob_pkg::OutDataW;
  localparam int BurstItems = 154;
  localparam int BurstCount = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [TintW-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;    // src_alpha 7:0, src_lum 15:8, dst_pixel 47:16
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;        // out_pixel 31:0
  logic                out_tuser;        // written 0
  int                  errors;
  int                  pending;
  logic                calm = 1'b0;
  int                  gap_odds = 4;

  always #6 clk = ~clk;

  tinted_premul_over_blend u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  over_blend_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending)
  );

  // Offer one item and hold it until taken; sometimes leave a gap afterwards.
  task automatic push_pixel(input logic [7:0] alpha, input logic [7:0] lum,
                            input logic [31:0] dst);
    in_tvalid <= 1'b1;
    in_tdata  <= {dst, lum, alpha};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // The count is sampled on the falling edge, after the checker has updated it.
  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_tint(input logic [TintW-1:0] value);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Alpha and luminance lean toward the values where the blend changes form.
  function automatic logic [7:0] draw_level();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: begin
        return 8'h00;
      end
      3, 4, 5: begin
        return 8'hFF;
      end
      6: begin
        return 8'h01;
      end
      7: begin
        return 8'hFE;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Receiver side: random stall bursts mixed with stretches of steady acceptance.
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL tinted_premul_over_blend");
    $finish;
  end

  initial begin
    logic [TintW-1:0] tint;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the tint left by reset.
    push_pixel(8'h00, 8'h00, 32'h0000_0000);
    push_pixel(8'hFF, 8'h00, 32'hFFFF_FFFF);
    push_pixel(8'h80, 8'hFF, 32'h1234_5678);
    push_pixel(8'h01, 8'h00, 32'hFFFF_FFFF);
    push_pixel(8'hFE, 8'h7F, 32'h0000_0000);
    push_pixel(8'h00, 8'hFF, 32'hFFFF_FFFF);

    // Directed items with one channel at each extreme and one in between.
    set_tint(24'hFF8000);
    push_pixel(8'h00, 8'h00, 32'h0000_0000);
    push_pixel(8'h00, 8'hFF, 32'hFFFF_FFFF);
    push_pixel(8'h00, 8'h5A, 32'h1234_5678);
    push_pixel(8'hFF, 8'h00, 32'h0000_0000);
    push_pixel(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_pixel(8'hFF, 8'h80, 32'hA5A5_A5A5);
    push_pixel(8'h01, 8'h00, 32'hFFFF_FFFF);
    push_pixel(8'hFE, 8'hFF, 32'h0000_0000);
    push_pixel(8'h80, 8'h00, 32'hFFFF_FFFF);
    push_pixel(8'h80, 8'hFF, 32'h0000_0000);
    push_pixel(8'h01, 8'hFF, 32'h8080_8080);
    push_pixel(8'hFE, 8'h00, 32'h7F7F_7F7F);
    push_pixel(8'h55, 8'hAA, 32'hDEAD_BEEF);

    for (int burst = 0; burst < BurstCount; burst++) begin
      if (burst == 0)
        tint = 24'hFFFFFF;
      else if (burst == 1)
        tint = 24'h000000;
      else
        tint = TintW'($urandom);
      set_tint(tint);
      // The last burst runs with no idling on either side.
      calm = (burst == BurstCount - 1);
      case ($urandom_range(0, 2))
        0: begin
          gap_odds = 0;
        end
        1: begin
          gap_odds = 8;
        end
        default: begin
          gap_odds = 2;
        end
      endcase
      for (int n = 0; n < BurstItems; n++)
        push_pixel(draw_level(), draw_level(), $urandom);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS tinted_premul_over_blend");
    else
      $display("FAIL tinted_premul_over_blend");
    $finish;
  end

endmodule

// ----- tinted_premul_over_blend.f -----
+incdir+hw/rtl
hw/rtl/tpob_pkg.sv
hw/rtl/tinted_premul_over_blend.sv
bench/over_blend_checker.sv
bench/tb.sv
